// File: hdl/stereo_frame_byte_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo frame byte encoder
// Shared property shapes, clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_BYTE_ENCODER_TOP_MACROS_SVH
`define STEREO_FRAME_BYTE_ENCODER_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define SFBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SFBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sfbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbe_pkg
// Shared types, constants and elaboration-time soft-clip table builder.
// ----------------------------------------------------------------------------
package sfbe_pkg;

    localparam int PipeStages = 6;

    localparam int ScaledBits = 24;              // Q1.23 working scale
    localparam int AbsBits    = ScaledBits + 1;  // |L+R| on the Q1.23 scale
    localparam int GateBits   = 15;
    localparam int ClipBits   = 16;              // table entries, 32768 = 1.0
    localparam int MagBits    = 15;
    localparam int Q15Bits    = 15;

    localparam logic [MagBits-1:0] MagLimit = 15'd27525;  // 0.84 in Q15

    localparam int LoudScale = 7;
    localparam int QuietMul  = 15;

    localparam logic [2:0] QuietCap = 3'd4;
    localparam logic [2:0] QuietMid = 3'd3;

    localparam logic [7:0] CodeLoud = 8'h80;
    localparam logic [7:0] CodeSign = 8'h08;

    localparam int          Frac28 = 28;
    localparam logic [63:0] One28  = 64'd1 << Frac28;
    localparam logic [63:0] Q15One = 64'd32768;

    // Side information that travels with a frame down the pipeline.
    typedef struct packed {
        logic       last;
        logic       neg;
        logic       quiet;
        logic [2:0] qlev_l;
        logic [2:0] qlev_r;
    } t_side;

    // Shift-subtract division, for building the clip table at elaboration.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(y) with y and the result in Q28, truncated series terms.
    function automatic logic [63:0] exp_q28(logic [63:0] y);
        logic [63:0] term;
        logic [63:0] acc;
        term = One28;
        acc  = One28;
        for (int n = 1; n < 48; n++) begin
            if (term != 0) begin
                term = udiv64((term * y) >> Frac28, 64'(n));
                acc  = acc + term;
            end
        end
        return acc;
    endfunction

    // tanh(1.2 * k / 2^tbits) in Q28.
    function automatic logic [63:0] tanh_q28(logic [63:0] k, int tbits);
        logic [63:0] den;
        logic [63:0] y;
        logic [63:0] e;
        den = 64'd5 << tbits;
        y   = udiv64(((k * 64'd12) << Frac28) + (den >> 1), den);
        e   = exp_q28(y);
        return udiv64((e - One28) << Frac28, e + One28);
    endfunction

    function automatic logic [63:0] clip_top(int tbits);
        logic [63:0] t;
        t = tanh_q28(64'd1 << tbits, tbits);
        return (t == 0) ? 64'd1 : t;
    endfunction

    function automatic logic [63:0] clip_entry(logic [63:0] k, int tbits, logic [63:0] top);
        return udiv64(tanh_q28(k, tbits) * Q15One + (top >> 1), top);
    endfunction

endpackage

// File: hdl/sfbe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbe_in_if / sfbe_out_if
// Valid/ready channels for stereo frames in and code bytes out.
// ----------------------------------------------------------------------------
interface sfbe_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;

    modport source (output valid, left_sample, right_sample, last_frame, input ready);
    modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface sfbe_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] code;
    logic       last;

    modport source (output valid, code, last, input ready);
    modport sink   (input valid, code, last, output ready);
endinterface

// File: hdl/sfbe_clip_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbe_clip_rom
// One bank (even or odd entries) of the soft-clip table, registered read.
// ----------------------------------------------------------------------------
module sfbe_clip_rom
    import sfbe_pkg::*;
#(
    parameter int TABLE_BITS = 10,
    parameter bit ODD        = 1'b0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [$clog2(ODD ? 2**(TABLE_BITS-1) : 2**(TABLE_BITS-1)+1)-1:0] i_addr,
    output logic [ClipBits-1:0]                o_data
);
    localparam int Depth = ODD ? 2**(TABLE_BITS-1) : 2**(TABLE_BITS-1) + 1;
    localparam logic [63:0] TopVal = clip_top(TABLE_BITS);

    logic [ClipBits-1:0] w_tab [Depth];
    logic [ClipBits-1:0] r_data;

    for (genvar k = 0; k < Depth; k++) begin : g_tab
        localparam logic [63:0] Entry = clip_entry(64'(2 * k + int'(ODD)), TABLE_BITS, TopVal);
        assign w_tab[k] = Entry[ClipBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;
endmodule

// File: hdl/sfbe_clip_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbe_clip_interp
// Soft clip of the mid magnitude: table read, interpolate, limit. 3 stages.
// ----------------------------------------------------------------------------
module sfbe_clip_interp
    import sfbe_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic [PipeStages-1:0] i_ld,
    input  logic [AbsBits-1:0]    i_a,
    output logic [MagBits-1:0]    o_mag
);
    localparam int FracBits = AbsBits - 1 - TABLE_BITS;
    localparam int IdxBits  = TABLE_BITS + 1;
    localparam int ProdBits = ClipBits + FracBits;
    localparam logic [ProdBits:0] RoundHalf = (ProdBits + 1)'(1) << (FracBits - 1);

    logic [IdxBits-1:0]    w_idx;
    logic [IdxBits-1:0]    w_idx_p1;
    logic [ClipBits-1:0]   w_even_q;
    logic [ClipBits-1:0]   w_odd_q;
    logic [ClipBits-1:0]   w_lo;
    logic [ClipBits-1:0]   w_hi;
    logic [ClipBits-1:0]   w_d;
    logic [ProdBits-1:0]   w_prod;
    logic [ProdBits:0]     w_round;
    logic [ClipBits:0]     w_sum;

    logic [FracBits-1:0]   r_frac;
    logic                  r_par;
    logic [ClipBits-1:0]   r_lo;
    logic [ProdBits-1:0]   r_prod;
    logic [MagBits-1:0]    r_mag;

    assign w_idx    = i_a[AbsBits-1:FracBits];
    assign w_idx_p1 = w_idx + 1'b1;

    // Even bank serves T[i] for even i and T[i+1] for odd i; odd bank the rest.
    sfbe_clip_rom #(.TABLE_BITS(TABLE_BITS), .ODD(1'b0)) u_even (
        .i_clk  (i_clk),
        .i_en   (i_ld[1]),
        .i_addr (w_idx_p1[IdxBits-1:1]),
        .o_data (w_even_q)
    );

    sfbe_clip_rom #(.TABLE_BITS(TABLE_BITS), .ODD(1'b1)) u_odd (
        .i_clk  (i_clk),
        .i_en   (i_ld[1]),
        .i_addr (w_idx[IdxBits-2:1]),
        .o_data (w_odd_q)
    );

    always_comb begin
        w_lo    = r_par ? w_odd_q : w_even_q;
        w_hi    = r_par ? w_even_q : w_odd_q;
        w_d     = w_hi - w_lo;
        w_prod  = ProdBits'(w_d) * ProdBits'(r_frac);
        w_round = (ProdBits + 1)'(r_prod) + RoundHalf;
        w_sum   = (ClipBits + 1)'(r_lo) + w_round[ProdBits:FracBits];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_frac <= i_a[FracBits-1:0];
            r_par  <= w_idx[0];
        end
        if (i_ld[2]) begin
            r_lo   <= w_lo;
            r_prod <= w_prod;
        end
        if (i_ld[3]) begin
            r_mag <= (w_sum > (ClipBits + 1)'(MagLimit)) ? MagLimit : w_sum[MagBits-1:0];
        end
    end

    assign o_mag = r_mag;
endmodule

// File: hdl/sfbe_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbe_level
// Loud-frame channel levels by threshold compare, and code byte assembly.
// ----------------------------------------------------------------------------
module sfbe_level
    import sfbe_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [PipeStages-1:0]  i_ld,
    input  t_side                  i_side,
    input  logic [SAMPLE_BITS-1:0] i_al,
    input  logic [SAMPLE_BITS-1:0] i_ar,
    input  logic [SAMPLE_BITS-1:0] i_mx,
    input  logic [MagBits-1:0]     i_mag,
    output logic [7:0]             o_code,
    output logic                   o_last
);
    localparam int PBits = MagBits + SAMPLE_BITS;
    localparam int WBits = SAMPLE_BITS + MagBits + 5;

    logic [PBits-1:0]     r_pl;
    logic [PBits-1:0]     r_pr;
    logic [SAMPLE_BITS-1:0] r_mx;
    t_side                r_side;
    logic [7:0]           r_code;
    logic                 r_last;

    logic [WBits-1:0]     w_lhs_l;
    logic [WBits-1:0]     w_lhs_r;
    logic [WBits-1:0]     w_thr;
    logic [LoudScale-1:0] w_ge_l;
    logic [LoudScale-1:0] w_ge_r;
    logic [2:0]           w_lev_l;
    logic [2:0]           w_lev_r;
    logic [7:0]           w_code;

    // Level >= k exactly when 14*mag*ch >= (2k-1)*mx*2^15.
    always_comb begin
        w_lhs_l = WBits'(r_pl) * WBits'(2 * LoudScale);
        w_lhs_r = WBits'(r_pr) * WBits'(2 * LoudScale);
        w_thr   = '0;
        for (int k = 1; k <= LoudScale; k++) begin
            w_thr         = (WBits'(r_mx) * WBits'(2 * k - 1)) << Q15Bits;
            w_ge_l[k - 1] = w_lhs_l >= w_thr;
            w_ge_r[k - 1] = w_lhs_r >= w_thr;
        end
        w_lev_l = (r_mx == '0) ? 3'd0 : 3'($countones(w_ge_l));
        w_lev_r = (r_mx == '0) ? 3'd0 : 3'($countones(w_ge_r));
        if (r_side.quiet) begin
            w_code = {1'b0, r_side.qlev_l, 1'b0, r_side.qlev_r};
        end else begin
            w_code = CodeLoud | {1'b0, w_lev_l, 4'b0000} | {5'b00000, w_lev_r}
                   | (r_side.neg ? CodeSign : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_pl   <= PBits'(i_mag) * PBits'(i_al);
            r_pr   <= PBits'(i_mag) * PBits'(i_ar);
            r_mx   <= i_mx;
            r_side <= i_side;
        end
        if (i_ld[5]) begin
            r_code <= w_code;
            r_last <= r_side.last;
        end
    end

    assign o_code = r_code;
    assign o_last = r_last;
endmodule

// File: hdl/stereo_frame_byte_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_frame_byte_encoder_top
// Stereo frame to code byte encoder with soft-clipped mid and level gate.
// ----------------------------------------------------------------------------
// One stereo frame in, one code byte out. The block is a six-stage pipeline
// that accepts a frame on every clock and delivers its byte in frame order when
// the output side keeps up; a stalled output holds the pipeline from the
// back, bubbles are squeezed out, and nothing is dropped or repeated. The
// latency is set by the table read, the interpolation multiply and the
// level multiply, each of which owns a stage. The soft-clip table is built at
// elaboration into two constant banks (even and odd entries) so that both
// neighbours of an interpolation pair come out in one read; there is no
// clearing pass after reset. gate_level is written through i_cfg_wr_en and
// i_cfg_wr_data and resets to zero, which makes every frame loud. Write it
// only while no frame is in flight.
// ----------------------------------------------------------------------------
`include "stereo_frame_byte_encoder_top_macros.svh"

module stereo_frame_byte_encoder_top
    import sfbe_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int CLIP_TABLE_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [GateBits-1:0] i_cfg_wr_data,
    sfbe_in_if.sink             i_in,
    sfbe_out_if.source          o_out
);
    localparam int SB      = SAMPLE_BITS;
    localparam int ScaleSh = ScaledBits - SB;   // raw sample to Q1.23
    localparam int LastSt  = PipeStages - 1;

    typedef struct packed {
        logic [SB-1:0] al;
        logic [SB-1:0] ar;
        logic [SB-1:0] mx;
    } t_mags;

    // Quiet level: q = min(floor(15*|ch|), 4); 3+q when negative, else |3-q|.
    function automatic logic [2:0] quiet_lev(logic [ScaledBits-1:0] ch, logic neg);
        logic [ScaledBits+3:0] p;
        logic [4:0]            q5;
        logic [2:0]            q;
        p  = (ScaledBits + 4)'(ch) * (ScaledBits + 4)'(QuietMul);
        q5 = p[ScaledBits+3:ScaledBits-1];
        q  = (q5 > 5'(QuietCap)) ? QuietCap : q5[2:0];
        if (neg) begin
            return QuietMid + q;
        end
        return (q > QuietMid) ? (q - QuietMid) : (QuietMid - q);
    endfunction

    // Handshake: valid per stage, ready ripples back from the output.
    logic [PipeStages-1:0] r_vld;
    logic [PipeStages-1:0] w_rdy;

    logic [GateBits-1:0]   r_gate;

    // Stage 0: magnitudes, mid sum and its sign.
    logic signed [SB-1:0]  w_l;
    logic signed [SB-1:0]  w_r;
    logic [SB:0]           w_sum;
    logic [SB:0]           w_a_raw;
    logic [SB-1:0]         w_al;
    logic [SB-1:0]         w_ar;
    logic [SB-1:0]         r_al0;
    logic [SB-1:0]         r_ar0;
    logic [SB:0]           r_a0;
    logic                  r_neg0;
    logic                  r_last0;

    // Stage 1: gate decision and quiet levels; table read in the clip unit.
    logic [SB-1:0]         w_mx;
    logic [ScaledBits-1:0] w_mx24;
    logic                  w_quiet;
    logic [AbsBits-1:0]    w_a;
    t_side                 w_side1;
    t_side                 r_side1;
    t_side                 r_side2;
    t_side                 r_side3;
    t_mags                 r_mags1;
    t_mags                 r_mags2;
    t_mags                 r_mags3;

    logic [MagBits-1:0]    w_mag;
    logic [7:0]            w_code;
    logic                  w_last;

    always_comb begin
        w_rdy[LastSt] = !r_vld[LastSt] || o_out.ready;
        for (int k = LastSt - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < PipeStages; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= '0;
        end else if (i_cfg_wr_en) begin
            r_gate <= i_cfg_wr_data;
        end
    end

    assign i_in.ready = w_rdy[0];

    // Full-scale negative input comes out as exactly 1.0 in magnitude.
    always_comb begin
        w_l     = i_in.left_sample;
        w_r     = i_in.right_sample;
        w_sum   = {w_l[SB-1], w_l} + {w_r[SB-1], w_r};
        w_a_raw = w_sum[SB] ? (~w_sum + 1'b1) : w_sum;
        w_al    = w_l[SB-1] ? (~w_l + 1'b1) : w_l;
        w_ar    = w_r[SB-1] ? (~w_r + 1'b1) : w_r;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_al0   <= w_al;
            r_ar0   <= w_ar;
            r_a0    <= w_a_raw;
            r_neg0  <= w_sum[SB];
            r_last0 <= i_in.last_frame;
        end
    end

    always_comb begin
        w_mx           = (r_al0 > r_ar0) ? r_al0 : r_ar0;
        w_mx24         = ScaledBits'(w_mx) << ScaleSh;
        w_quiet        = w_mx24 < {1'b0, r_gate, 8'h00};
        w_a            = AbsBits'(r_a0) << ScaleSh;
        w_side1.last   = r_last0;
        w_side1.neg    = r_neg0;
        w_side1.quiet  = w_quiet;
        w_side1.qlev_l = quiet_lev(ScaledBits'(r_al0) << ScaleSh, r_neg0);
        w_side1.qlev_r = quiet_lev(ScaledBits'(r_ar0) << ScaleSh, r_neg0);
    end

    // Carry side data and magnitudes alongside the clip unit's three stages.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_side1    <= w_side1;
            r_mags1.al <= r_al0;
            r_mags1.ar <= r_ar0;
            r_mags1.mx <= w_mx;
        end
        if (w_rdy[2]) begin
            r_side2 <= r_side1;
            r_mags2 <= r_mags1;
        end
        if (w_rdy[3]) begin
            r_side3 <= r_side2;
            r_mags3 <= r_mags2;
        end
    end

    sfbe_clip_interp #(.TABLE_BITS(CLIP_TABLE_BITS)) u_clip (
        .i_clk (i_clk),
        .i_ld  (w_rdy),
        .i_a   (w_a),
        .o_mag (w_mag)
    );

    sfbe_level #(.SAMPLE_BITS(SAMPLE_BITS)) u_level (
        .i_clk  (i_clk),
        .i_ld   (w_rdy),
        .i_side (r_side3),
        .i_al   (r_mags3.al),
        .i_ar   (r_mags3.ar),
        .i_mx   (r_mags3.mx),
        .i_mag  (w_mag),
        .o_code (w_code),
        .o_last (w_last)
    );

    assign o_out.valid = r_vld[LastSt];
    assign o_out.code  = w_code;
    assign o_out.last  = w_last;

    // A quiet byte never carries the sign bit.
    `SFBE_ASSERT_NOW(a_quiet_no_sign, o_out.valid && !o_out.code[7], !o_out.code[3], "quiet code with sign bit set")
    // With the mid limited to 0.84, a loud level cannot reach 7.
    `SFBE_ASSERT_NOW(a_loud_level_range, o_out.valid && o_out.code[7], (o_out.code[6:4] != 3'd7) && (o_out.code[2:0] != 3'd7), "loud level out of range")
    // A frame in the last inner stage moves into the output register when it is free.
    `SFBE_ASSERT_NEXT(a_advance_out, w_rdy[LastSt] && r_vld[LastSt-1], o_out.valid, "frame lost entering output register")
endmodule

// File: bench/stereo_frame_byte_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_frame_byte_encoder_top_tb
// Self-checking bench for the stereo frame to code byte encoder.
// ----------------------------------------------------------------------------
// Frames go in through a bursty valid/ready source. A scoreboard computes each
// frame's code byte and last flag when the frame is accepted, then checks them
// against the output beats in order. The output side stalls on a shifting
// pattern. Directed tests cover zero and full-scale frames, both sides of the
// level gate and every quiet level. Random phases then sweep the gate from
// zero to full scale.
// ----------------------------------------------------------------------------
module stereo_frame_byte_encoder_top_tb;
    import sfbe_pkg::*;

    localparam int SampleBits  = 16;
    localparam int TableBits   = 10;
    localparam int TableTop    = 1 << TableBits;
    localparam int InterpShift = 24 - TableBits;
    localparam int ClkHalf     = 6;
    localparam int ResetCycles = 5;
    localparam int DrainCycles = 12;       // pipeline is six deep
    localparam int PhaseFrames = 125;
    localparam int CycleLimit  = 400000;
    localparam int MaxPrinted  = 20;

    typedef logic signed [SampleBits-1:0] sample_t;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_beat_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [GateBits-1:0] cfg_wr_data;

    sfbe_in_if #(.SAMPLE_BITS(SampleBits)) frame_if ();
    sfbe_out_if                             byte_if ();

    stereo_frame_byte_encoder_top #(
        .SAMPLE_BITS     (SampleBits),
        .CLIP_TABLE_BITS (TableBits)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (frame_if),
        .o_out         (byte_if)
    );

    // Scoreboard state: soft-clip table, shadow of the gate register and the
    // queue of code bytes still owed by the block.
    longint              clip_lut [0:TableTop];
    logic [GateBits-1:0] gate_now;
    code_beat_t          pending_codes [$];

    int error_count;
    int frames_sent;
    int gate_writes;
    int loud_seen;
    int quiet_seen;
    int burst_left;
    int cycle_count;

    // ------------------------------------------------------------------------
    // Soft-clip table: tanh(1.2x)/tanh(1.2) in Q15, from a truncated Q28 series
    // ------------------------------------------------------------------------
    function automatic longint unsigned exp_fix28(longint unsigned y);
        longint unsigned term;
        longint unsigned acc;
        term = 64'd1 << 28;
        acc  = 64'd1 << 28;
        for (int n = 1; n < 48 && term != 0; n++) begin
            term = ((term * y) >> 28) / 64'(n);
            acc  = acc + term;
        end
        return acc;
    endfunction

    function automatic longint unsigned tanh_fix28(longint unsigned k);
        longint unsigned den;
        longint unsigned y;
        longint unsigned e;
        den = 64'd5 << TableBits;
        y   = (((k * 64'd12) << 28) + den / 2) / den;
        e   = exp_fix28(y);
        return ((e - (64'd1 << 28)) << 28) / (e + (64'd1 << 28));
    endfunction

    function automatic void fill_clip_lut();
        longint unsigned top;
        top = tanh_fix28(64'(TableTop));
        if (top == 0)
            top = 1;
        for (int k = 0; k <= TableTop; k++)
            clip_lut[k] = longint'((tanh_fix28(64'(k)) * 64'd32768 + top / 2) / top);
    endfunction

    // Interpolate the table at a (units of 2^-24) and hold at the 0.84 limit.
    function automatic longint clipped_mid(longint a);
        longint idx;
        longint frac;
        longint y;
        idx  = a >>> InterpShift;
        frac = a & ((64'sd1 <<< InterpShift) - 1);
        if (idx >= TableTop) begin
            y = clip_lut[TableTop];
        end else begin
            y = clip_lut[idx] + (((clip_lut[idx + 1] - clip_lut[idx]) * frac
                                  + (64'sd1 <<< (InterpShift - 1))) >>> InterpShift);
        end
        return (y > longint'(MagLimit)) ? longint'(MagLimit) : y;
    endfunction

    function automatic logic [2:0] loud_level(longint mag, longint ch, longint mx);
        longint num;
        longint den;
        longint v;
        if (mx == 0)
            return 3'd0;
        num = 7 * mag * ch;
        den = 32768 * mx;
        v   = (2 * num + den) / (2 * den);
        return (v > 7) ? 3'd7 : 3'(v);
    endfunction

    function automatic logic [2:0] quiet_level(longint ch, logic neg);
        longint q;
        q = (15 * ch) >>> 23;
        if (q > 4)
            q = 4;
        if (neg)
            return 3'(3 + q);
        return (q > 3) ? 3'(q - 3) : 3'(3 - q);
    endfunction

    // Code byte for one frame under the given gate level.
    function automatic logic [7:0] encode_frame(sample_t left, sample_t right,
                                                logic [GateBits-1:0] gate);
        longint     sl;
        longint     sr;
        longint     mid;
        longint     al;
        longint     ar;
        longint     mx;
        longint     mag;
        logic       neg;
        logic [7:0] code;
        sl  = longint'(left) * 256;
        sr  = longint'(right) * 256;
        mid = sl + sr;
        neg = (mid < 0);
        if (neg)
            mid = -mid;
        al  = (sl < 0) ? -sl : sl;
        ar  = (sr < 0) ? -sr : sr;
        mx  = (al > ar) ? al : ar;
        if (mx < (longint'(gate) << 8)) begin
            code = {1'b0, quiet_level(al, neg), 1'b0, quiet_level(ar, neg)};
        end else begin
            mag  = clipped_mid(mid);
            code = CodeLoud | {1'b0, loud_level(mag, al, mx), 1'b0, loud_level(mag, ar, mx)};
            if (neg)
                code = code | CodeSign;
        end
        return code;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #(ClkHalf) clk = ~clk;
    end

    // Give up on a hung pipeline.
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d code bytes still owed",
                 cycle_count, pending_codes.size());
        $display("stereo_frame_byte_encoder_top_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output stall pattern: pick a 32-bit ready mask, then walk through it.
    // Masks range from always ready through random to a long solid stall.
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] ready_mask;
        int          slot;
        byte_if.ready = 1'b0;
        ready_mask    = '1;
        slot          = 0;
        forever begin
            @(negedge clk);
            if (slot == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    ready_mask = '1;
                    2:       ready_mask = $urandom | $urandom;
                    3:       ready_mask = $urandom;
                    default: ready_mask = 32'h0000_ffff << $urandom_range(0, 16);
                endcase
            end
            byte_if.ready <= ready_mask[slot];
            slot = (slot + 1) % 32;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on every accepted frame beat, check every byte beat
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MaxPrinted)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge clk) begin
        code_beat_t owed;
        if (rst_n && frame_if.valid && frame_if.ready) begin
            owed.code = encode_frame(frame_if.left_sample, frame_if.right_sample, gate_now);
            owed.last = frame_if.last_frame;
            pending_codes.push_back(owed);
        end
    end

    always @(posedge clk) begin
        code_beat_t owed;
        if (rst_n && byte_if.valid && byte_if.ready) begin
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("code 0x%02h arrived with no frame owed",
                                          byte_if.code));
            end else begin
                owed = pending_codes.pop_front();
                if (owed.code[7])
                    loud_seen++;
                else
                    quiet_seen++;
                if (byte_if.code !== owed.code)
                    report_mismatch($sformatf("code 0x%02h, wanted 0x%02h",
                                              byte_if.code, owed.code));
                if (byte_if.last !== owed.last)
                    report_mismatch($sformatf("last %b, wanted %b with code 0x%02h",
                                              byte_if.last, owed.last, owed.code));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Frame source. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------------

    // Drive one frame and hold it until it is taken. Between bursts, valid
    // may drop for a random gap; inside a burst keep valid high back to back.
    task automatic send_frame(input sample_t left, input sample_t right, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                frame_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        frame_if.valid        <= 1'b1;
        frame_if.left_sample  <= left;
        frame_if.right_sample <= right;
        frame_if.last_frame   <= last;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        @(negedge clk);
        frames_sent++;
    endtask

    // Stop sending and let every owed byte come out, then let the pipe empty.
    task automatic wait_for_drain();
        frame_if.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Only ever called with nothing in flight.
    task automatic write_gate(input logic [GateBits-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        gate_now   = value;
        gate_writes++;
    endtask

    // Random sample: mostly full range, with weight on small levels (quiet
    // codes), values right at the gate and the rails.
    function automatic sample_t pick_sample(logic [GateBits-1:0] gate);
        int mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5:       return sample_t'(int'($urandom_range(0, 18000)) - 9000);
            6: begin
                mag = int'(gate) + int'($urandom_range(0, 4)) - 2;
                if (mag < 0)
                    mag = 0;
                if (mag > 32767)
                    mag = 32767;
                return $urandom_range(0, 1) ? sample_t'(-mag) : sample_t'(mag);
            end
            7: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sh0001;
                    3:       return 16'shffff;
                    default: return 16'sh0000;
                endcase
            end
            8:       return sample_t'(int'($urandom_range(0, 65535)) - 32768) >>> 2;
            default: return 16'sh0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Gate left at its reset value of zero: every frame is loud.
    task automatic test_reset_gate_loud();
        send_frame(16'sh0000, 16'sh0000, 1'b0);   // silent frame, ratio held at zero
        send_frame(16'sh7fff, 16'sh7fff, 1'b1);
        send_frame(16'sh8000, 16'sh8000, 1'b0);   // full-scale negative on both sides
        send_frame(16'sh7fff, 16'sh8000, 1'b1);
        send_frame(16'sh8000, 16'sh0000, 1'b0);
        send_frame(16'sh0000, 16'sh7fff, 1'b0);
        send_frame(16'shffff, 16'sh0000, 1'b1);   // tiny negative mid, sign kept
        send_frame(16'sh0001, 16'shffff, 1'b0);   // mid exactly zero
        send_frame(16'sh4000, -16'sh4000, 1'b1);
        wait_for_drain();
    endtask

    // Gate at an eighth of full scale: frames just under, just at and well above the threshold.
    task automatic test_gate_threshold();
        write_gate(15'd4096);
        send_frame(16'sd4095, -16'sd4095, 1'b0);
        send_frame(16'sd4096, 16'sd0, 1'b1);
        send_frame(-16'sd4096, 16'sd4095, 1'b0);
        send_frame(16'sd20000, 16'sd5000, 1'b0);
        send_frame(-16'sd12000, 16'sd30000, 1'b1);
        send_frame(16'sd3000, -16'sd30000, 1'b0);
        wait_for_drain();
    endtask

    // Gate at full scale: walk each quiet level with both mid signs.
    task automatic test_quiet_levels();
        write_gate(15'h7fff);
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(16'sd2185, -16'sd2185, 1'b1);
        send_frame(16'sd4370, 16'sd6554, 1'b0);
        send_frame(16'sd8739, 16'sd32766, 1'b0);   // level capped, still under the gate
        send_frame(-16'sd2185, -16'sd4370, 1'b1);
        send_frame(-16'sd6554, -16'sd8739, 1'b0);
        send_frame(-16'sd32767, 16'sd100, 1'b0);
        send_frame(16'sd1, -16'sd2, 1'b1);
        send_frame(16'sd32767, 16'sd0, 1'b0);      // at the gate, so loud
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        wait_for_drain();
    endtask

    // Random frames under a sweep of gate levels, extremes included.
    task automatic test_random_frames();
        logic [GateBits-1:0] gate_list [6];
        sample_t             left;
        sample_t             right;
        int                  near;
        gate_list[0] = '0;
        gate_list[1] = '1;
        gate_list[2] = 15'($urandom_range(1, 9000));
        gate_list[3] = 15'($urandom_range(9000, 32766));
        gate_list[4] = 15'd1;
        gate_list[5] = 15'($urandom_range(0, 32767));
        foreach (gate_list[p]) begin
            write_gate(gate_list[p]);
            repeat (PhaseFrames) begin
                left = pick_sample(gate_list[p]);
                if ($urandom_range(0, 3) == 0) begin
                    // Mirror the left sample so the mid lands near zero.
                    near = -int'(left) + int'($urandom_range(0, 64)) - 32;
                    if (near > 32767)
                        near = 32767;
                    if (near < -32768)
                        near = -32768;
                    right = sample_t'(near);
                end else begin
                    right = pick_sample(gate_list[p]);
                end
                send_frame(left, right, 1'($urandom));
            end
            wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        frame_if.valid        = 1'b0;
        frame_if.left_sample  = '0;
        frame_if.right_sample = '0;
        frame_if.last_frame   = 1'b0;
        gate_now              = '0;
        error_count           = 0;
        frames_sent           = 0;
        gate_writes           = 0;
        loud_seen             = 0;
        quiet_seen            = 0;
        burst_left            = 0;
        fill_clip_lut();

        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_gate_loud();
        test_gate_threshold();
        test_quiet_levels();
        test_random_frames();

        $display("%0d frames over %0d gate settings: %0d loud and %0d quiet codes checked",
                 frames_sent, gate_writes + 1, loud_seen, quiet_seen);
        if (error_count == 0) begin
            $display("stereo_frame_byte_encoder_top_tb passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("stereo_frame_byte_encoder_top_tb failed");
        end
        $finish;
    end

endmodule
